/* rtl/hdus_pkg.sv */
// ----------------------------------------------------------------------------
// hdus_pkg
// Shared constants and lookup functions for the HTTP date to Unix seconds
// core: month name table, cumulative month starts and the sequencer step
// table of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package hdus_pkg;

  // multiply-accumulate unit widths
  localparam int ACC_W   = 32;
  localparam int MAC_A_W = 32;
  localparam int MAC_B_W = 17;

  // number of multiply-accumulate steps per date
  localparam int NUM_STEPS = 10;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // step codes
  localparam logic [STEP_W-1:0] ST_YEAR   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_LEAP   = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_DAY    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_SCALE  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_HOUR10 = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_HOUR1  = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_MIN10  = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_MIN1   = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_SEC10  = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_SEC1   = STEP_W'(9);

  // date constants
  localparam logic [15:0] YEAR_MIN = 16'd1970;
  localparam logic [15:0] YEAR_MAX = 16'd2105;
  localparam logic [15:0] YEAR_NO_LEAP = 16'd2100;
  localparam logic [MAC_B_W-1:0] DAYS_PER_YEAR = MAC_B_W'(365);
  localparam logic [MAC_B_W-1:0] SECS_PER_DAY  = MAC_B_W'(86400);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [287:0] MONTH_NAMES = "JanFebMarAprMayJunJulAugSepOctNovDec";

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } month_hit_t;

  // match three packed month bytes against the name table
  function automatic month_hit_t find_month(input logic [23:0] chars);
    month_hit_t r;
    r.hit = 1'b0;
    r.idx = 4'd0;
    for (int i = 11; i >= 0; i--) begin
      if (MONTH_NAMES[287 - i*24 -: 24] == chars) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

  // days before the first of each month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // time byte used by each time step
  function automatic logic [2:0] step_time_idx(input logic [STEP_W-1:0] step);
    logic [2:0] r;
    case (step)
      ST_HOUR10: r = 3'd0;
      ST_HOUR1:  r = 3'd1;
      ST_MIN10:  r = 3'd3;
      ST_MIN1:   r = 3'd4;
      ST_SEC10:  r = 3'd6;
      ST_SEC1:   r = 3'd7;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  // weight of each time byte in seconds
  function automatic logic [MAC_B_W-1:0] step_time_weight(input logic [STEP_W-1:0] step);
    logic [MAC_B_W-1:0] r;
    case (step)
      ST_HOUR10: r = MAC_B_W'(36000);
      ST_HOUR1:  r = MAC_B_W'(3600);
      ST_MIN10:  r = MAC_B_W'(600);
      ST_MIN1:   r = MAC_B_W'(60);
      ST_SEC10:  r = MAC_B_W'(10);
      ST_SEC1:   r = MAC_B_W'(1);
      default:   r = MAC_B_W'(1);
    endcase
    return r;
  endfunction

endpackage

/* rtl/http_date_to_unix_seconds_core.sv */
// ----------------------------------------------------------------------------
// http_date_to_unix_seconds_core
// Parses an HTTP date one character per item and gives Unix seconds and an
// error flag at the final character.
// Non-final characters are taken one per cycle while the core is idle.
// After the final character the core stalls input while it checks the date,
// runs the 10 steps of the shared multiply-accumulate unit on a good date
// and delivers the result, and for as long as the output stalls; the result
// is valid in the cycle after that. Synchronous reset returns the parser to
// waiting for the comma and empties the output register.
// ----------------------------------------------------------------------------
module http_date_to_unix_seconds_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        final_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] unix_seconds,
  output logic        format_error
);

  // parse phases
  localparam logic [3:0] PH_COMMA = 4'd0;
  localparam logic [3:0] PH_SKIP1 = 4'd1;
  localparam logic [3:0] PH_DAY   = 4'd2;
  localparam logic [3:0] PH_SKIP2 = 4'd3;
  localparam logic [3:0] PH_MONTH = 4'd4;
  localparam logic [3:0] PH_SKIP3 = 4'd5;
  localparam logic [3:0] PH_YEAR  = 4'd6;
  localparam logic [3:0] PH_TIME  = 4'd7;
  localparam logic [3:0] PH_DONE  = 4'd8;

  // sequencer states
  localparam logic [1:0] SEQ_IDLE    = 2'd0;
  localparam logic [1:0] SEQ_CHECK   = 2'd1;
  localparam logic [1:0] SEQ_RUN     = 2'd2;
  localparam logic [1:0] SEQ_DELIVER = 2'd3;

  logic [1:0]                   seq;
  logic [hdus_pkg::STEP_W-1:0]  step;
  logic                         res_err;

  logic [3:0]  phase, phase_next;
  logic [15:0] day_accum, day_next;
  logic [23:0] month_chars, month_next;
  logic [15:0] year_accum, year_next;
  logic [3:0]  char_position, pos_next;
  logic        error_seen, err_next;
  logic [7:0]  time_chars [8];
  logic        time_we;

  logic        in_take;
  logic        out_free;
  logic        loading;

  logic [3:0]  cur;
  logic        handled;
  logic        is_digit;
  logic [19:0] day_sum, year_sum;

  hdus_pkg::month_hit_t mh;
  logic        bad_date;

  logic                          mac_en, mac_clr;
  logic [hdus_pkg::MAC_A_W-1:0]  mac_a;
  logic [hdus_pkg::MAC_B_W-1:0]  mac_b;
  logic [hdus_pkg::ACC_W-1:0]    acc;

  logic [15:0] year_off;
  logic [15:0] y1969, y1901;
  logic [1:0]  q100;
  logic        q400, leap;
  logic [10:0] small_sum;
  logic [8:0]  time_diff;

  // handshake
  assign in_stall = (seq != SEQ_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign loading  = (seq == SEQ_DELIVER) && out_free;

  // digit accumulators, saturating at 16 bits
  assign is_digit = (char_code >= hdus_pkg::CH_ZERO) && (char_code <= hdus_pkg::CH_NINE);
  assign day_sum  = {4'b0, day_accum} * 20'd10 + {16'b0, char_code[3:0]};
  assign year_sum = {4'b0, year_accum} * 20'd10 + {16'b0, char_code[3:0]};

  // character parser, phases fall through as in the string grammar
  always_comb begin
    phase_next = phase;
    day_next   = day_accum;
    month_next = month_chars;
    year_next  = year_accum;
    pos_next   = char_position;
    err_next   = error_seen;
    time_we    = 1'b0;
    cur        = phase;
    handled    = 1'b0;
    if (!error_seen && phase != PH_DONE) begin
      if (char_code == hdus_pkg::CH_NUL) begin
        err_next = 1'b1;
      end else begin
        if (cur == PH_COMMA) begin
          if (char_code == hdus_pkg::CH_COMMA) cur = PH_SKIP1;
          handled = 1'b1;
        end
        if (!handled && cur == PH_SKIP1) begin
          if (char_code == hdus_pkg::CH_SPACE) handled = 1'b1;
          else cur = PH_DAY;
        end
        if (!handled && cur == PH_DAY) begin
          if (is_digit) begin
            day_next = (day_sum > 20'd65535) ? 16'hFFFF : day_sum[15:0];
            handled  = 1'b1;
          end else begin
            cur = PH_SKIP2;
          end
        end
        if (!handled && cur == PH_SKIP2) begin
          if (char_code == hdus_pkg::CH_SPACE) begin
            handled = 1'b1;
          end else begin
            cur      = PH_MONTH;
            pos_next = 4'd0;
          end
        end
        if (!handled && cur == PH_MONTH) begin
          month_next = {month_chars[15:0], char_code};
          if (pos_next + 4'd1 >= 4'd3) begin
            cur      = PH_SKIP3;
            pos_next = 4'd0;
          end else begin
            pos_next = pos_next + 4'd1;
          end
          handled = 1'b1;
        end
        if (!handled && cur == PH_SKIP3) begin
          if (char_code == hdus_pkg::CH_SPACE) handled = 1'b1;
          else cur = PH_YEAR;
        end
        if (!handled && cur == PH_YEAR) begin
          if (is_digit) begin
            year_next = (year_sum > 20'd65535) ? 16'hFFFF : year_sum[15:0];
          end else if (char_code == hdus_pkg::CH_SPACE) begin
            cur      = PH_TIME;
            pos_next = 4'd0;
          end else begin
            err_next = 1'b1;
          end
          handled = 1'b1;
        end
        if (!handled && cur == PH_TIME) begin
          time_we  = 1'b1;
          pos_next = char_position + 4'd1;
          if (char_position + 4'd1 >= 4'd8) cur = PH_DONE;
          handled = 1'b1;
        end
        if (!handled) begin
          err_next = 1'b1;
        end
        phase_next = cur;
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst || loading) begin
      phase         <= PH_COMMA;
      day_accum     <= '0;
      month_chars   <= '0;
      year_accum    <= '0;
      char_position <= '0;
      error_seen    <= 1'b0;
    end else if (in_take) begin
      phase         <= phase_next;
      day_accum     <= day_next;
      month_chars   <= month_next;
      year_accum    <= year_next;
      char_position <= pos_next;
      error_seen    <= err_next;
    end
  end

  // time bytes
  always_ff @(posedge clk) begin
    if (in_take && time_we) begin
      time_chars[char_position[2:0]] <= char_code;
    end
  end

  // date checks
  assign mh       = hdus_pkg::find_month(month_chars);
  assign bad_date = error_seen || (phase != PH_DONE) || !mh.hit ||
                    (year_accum < hdus_pkg::YEAR_MIN) || (year_accum > hdus_pkg::YEAR_MAX);

  // leap-day and month terms, year known to be in range here
  // the sum is -1 for january of the first years, so it is taken as signed
  assign year_off  = year_accum - hdus_pkg::YEAR_MIN;
  assign y1969     = year_accum - 16'd1969;
  assign y1901     = year_accum - 16'd1901;
  assign q100      = (y1901 >= 16'd200) ? 2'd2 : ((y1901 >= 16'd100) ? 2'd1 : 2'd0);
  assign q400      = (year_accum >= 16'd2001);
  assign leap      = (mh.idx >= 4'd2) && (year_accum[1:0] == 2'b00) &&
                     (year_accum != hdus_pkg::YEAR_NO_LEAP);
  assign small_sum = {3'b0, y1969[9:2]} - {9'b0, q100} + {10'b0, q400}
                   + {2'b0, hdus_pkg::month_start(mh.idx)} + {10'b0, leap} - 11'd1;

  // selected time byte minus the digit zero, sign extended
  assign time_diff = {1'b0, time_chars[hdus_pkg::step_time_idx(step)]}
                   - {1'b0, hdus_pkg::CH_ZERO};

  // operand selection for the shared unit
  always_comb begin
    mac_en  = (seq == SEQ_RUN);
    mac_clr = 1'b0;
    mac_a   = {{(hdus_pkg::MAC_A_W-9){time_diff[8]}}, time_diff};
    mac_b   = hdus_pkg::step_time_weight(step);
    case (step)
      hdus_pkg::ST_YEAR: begin
        mac_clr = 1'b1;
        mac_a   = {{(hdus_pkg::MAC_A_W-8){1'b0}}, year_off[7:0]};
        mac_b   = hdus_pkg::DAYS_PER_YEAR;
      end
      hdus_pkg::ST_LEAP: begin
        mac_a = {{(hdus_pkg::MAC_A_W-11){small_sum[10]}}, small_sum};
        mac_b = hdus_pkg::MAC_B_W'(1);
      end
      hdus_pkg::ST_DAY: begin
        mac_a = {{(hdus_pkg::MAC_A_W-16){1'b0}}, day_accum};
        mac_b = hdus_pkg::MAC_B_W'(1);
      end
      hdus_pkg::ST_SCALE: begin
        mac_clr = 1'b1;
        mac_a   = acc;
        mac_b   = hdus_pkg::SECS_PER_DAY;
      end
      default: begin
      end
    endcase
  end

  hdus_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .clr  (mac_clr),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq     <= SEQ_IDLE;
      step    <= '0;
      res_err <= 1'b0;
    end else begin
      unique case (seq)
        SEQ_IDLE: begin
          if (in_take && final_char) seq <= SEQ_CHECK;
        end
        SEQ_CHECK: begin
          step <= '0;
          if (bad_date) begin
            res_err <= 1'b1;
            seq     <= SEQ_DELIVER;
          end else begin
            res_err <= 1'b0;
            seq     <= SEQ_RUN;
          end
        end
        SEQ_RUN: begin
          if (step == hdus_pkg::LAST_STEP) seq <= SEQ_DELIVER;
          else step <= step + 1'b1;
        end
        SEQ_DELIVER: begin
          if (out_free) seq <= SEQ_IDLE;
        end
        default: seq <= SEQ_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (loading) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (loading) begin
      unix_seconds <= res_err ? '0 : acc;
      format_error <= res_err;
    end
  end

  // checks
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && final_char) |=> in_stall)
    else $error("final item did not start the date computation");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && format_error) |-> (unix_seconds == 32'd0))
    else $error("error result carries nonzero seconds");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (seq == SEQ_RUN) |-> (step <= hdus_pkg::LAST_STEP))
    else $error("step counter ran past the last step");

  a_parser_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (phase == PH_COMMA && !error_seen))
    else $error("parser not cleared after a result");

endmodule

/* rtl/hdus_mac.sv */
// ----------------------------------------------------------------------------
// hdus_mac
// Shared multiply-accumulate unit: while en is high, acc <= (clr ? 0 : acc) + op_a * op_b,
// keeping the low bits, so the sum wraps modulo 2^ACC_W.
// ----------------------------------------------------------------------------
module hdus_mac (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         clr,
  input  logic [hdus_pkg::MAC_A_W-1:0] op_a,
  input  logic [hdus_pkg::MAC_B_W-1:0] op_b,
  output logic [hdus_pkg::ACC_W-1:0]   acc
);

  localparam int PW = hdus_pkg::MAC_A_W + hdus_pkg::MAC_B_W;

  logic [PW-1:0]                  prod;
  logic [hdus_pkg::ACC_W-1:0]     base;

  // product and accumulate base
  assign prod = {{hdus_pkg::MAC_B_W{1'b0}}, op_a} * {{hdus_pkg::MAC_A_W{1'b0}}, op_b};
  assign base = clr ? '0 : acc;

  // accumulator
  always_ff @(posedge clk) begin
    if (en) begin
      acc <= base + prod[hdus_pkg::ACC_W-1:0];
    end
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the HTTP date to Unix seconds core one character per item. A short
// directed set of strings comes first, then random date strings: mostly well
// formed with random fields, some truncated, broken by a zero byte or plain
// noise. A parser model in the scoreboard predicts the seconds value and the
// error flag at each final character. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_CHARS = 700;
  localparam int unsigned CUM_DAYS [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef enum bit [3:0] {
    WAIT_COMMA, SKIP_A, DAY_DIGITS, SKIP_B, MONTH_NAME, SKIP_C, YEAR_DIGITS,
    TIME_BYTES, ALL_TAKEN
  } parse_phase_e;

  typedef struct packed {
    bit [31:0] secs;
    bit        bad;
  } stamp_t;

  typedef bit [7:0] byte_q [$];

  // parser model and store of expected stamps
  class date_scoreboard;
    parse_phase_e phase = WAIT_COMMA;
    bit [15:0]    day_num;
    bit [15:0]    year_num;
    bit [23:0]    month_code;
    bit [7:0]     clock_bytes [8];
    int unsigned  pos;
    bit           faulted;
    stamp_t       pending_stamps [$];
    int unsigned  stamps_predicted;
    int unsigned  failures;

    // decimal accumulate, saturating at 16 bits
    static function bit [15:0] push_digit(bit [15:0] acc, bit [7:0] c);
      int unsigned v;
      v = 32'(acc) * 32'd10 + 32'(c) - 32'd48;
      return (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void note_char(bit [7:0] c, bit fin);
      bit          taken;
      bit          is_digit;
      int          month_idx;
      int unsigned y, days, hh, mm, ss;
      stamp_t      s;
      taken = 1'b0;
      is_digit = (c >= hdus_pkg::CH_ZERO) && (c <= hdus_pkg::CH_NINE);
      // one parse step, phases fall through until the char is taken
      if (!faulted && phase != ALL_TAKEN) begin
        if (c == hdus_pkg::CH_NUL) begin
          faulted = 1'b1;
        end else if (phase == WAIT_COMMA) begin
          if (c == hdus_pkg::CH_COMMA) phase = SKIP_A;
        end else begin
          if (phase == SKIP_A) begin
            if (c == hdus_pkg::CH_SPACE) taken = 1'b1;
            else phase = DAY_DIGITS;
          end
          if (!taken && phase == DAY_DIGITS) begin
            if (is_digit) begin
              day_num = push_digit(day_num, c);
              taken = 1'b1;
            end else begin
              phase = SKIP_B;
            end
          end
          if (!taken && phase == SKIP_B) begin
            if (c == hdus_pkg::CH_SPACE) begin
              taken = 1'b1;
            end else begin
              phase = MONTH_NAME;
              pos = 0;
            end
          end
          if (!taken && phase == MONTH_NAME) begin
            month_code = {month_code[15:0], c};
            pos++;
            if (pos >= 3) begin
              phase = SKIP_C;
              pos = 0;
            end
            taken = 1'b1;
          end
          if (!taken && phase == SKIP_C) begin
            if (c == hdus_pkg::CH_SPACE) taken = 1'b1;
            else phase = YEAR_DIGITS;
          end
          if (!taken && phase == YEAR_DIGITS) begin
            if (is_digit) begin
              year_num = push_digit(year_num, c);
            end else if (c == hdus_pkg::CH_SPACE) begin
              phase = TIME_BYTES;
              pos = 0;
            end else begin
              faulted = 1'b1;
            end
            taken = 1'b1;
          end
          if (!taken && phase == TIME_BYTES) begin
            clock_bytes[pos[2:0]] = c;
            pos++;
            if (pos >= 8) phase = ALL_TAKEN;
          end
        end
      end
      if (!fin) return;

      // date arithmetic at the final char
      s.secs = '0;
      s.bad = 1'b1;
      month_idx = -1;
      for (int i = 0; i < 12; i++) begin
        if (month_idx < 0 &&
            hdus_pkg::MONTH_NAMES[287 - i*24 -: 24] == month_code) month_idx = i;
      end
      y = 32'(year_num);
      if (!faulted && phase == ALL_TAKEN && month_idx >= 0 &&
          y >= 32'(hdus_pkg::YEAR_MIN) && y <= 32'(hdus_pkg::YEAR_MAX)) begin
        days = (y - 32'd1970) * 32'd365 + (y - 32'd1969) / 32'd4
             - (y - 32'd1901) / 32'd100 + (y - 32'd1601) / 32'd400
             + CUM_DAYS[month_idx] + 32'(day_num) - 32'd1;
        if (month_idx >= 2 &&
            (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0)) days++;
        hh = (32'(clock_bytes[0]) - 32'd48) * 32'd10 + (32'(clock_bytes[1]) - 32'd48);
        mm = (32'(clock_bytes[3]) - 32'd48) * 32'd10 + (32'(clock_bytes[4]) - 32'd48);
        ss = (32'(clock_bytes[6]) - 32'd48) * 32'd10 + (32'(clock_bytes[7]) - 32'd48);
        s.secs = days * 32'd86400 + hh * 32'd3600 + mm * 32'd60 + ss;
        s.bad = 1'b0;
      end
      pending_stamps.push_back(s);
      stamps_predicted++;

      // next string starts from a clean parser
      phase = WAIT_COMMA;
      day_num = '0;
      year_num = '0;
      month_code = '0;
      foreach (clock_bytes[i]) clock_bytes[i] = '0;
      pos = 0;
      faulted = 1'b0;
    endfunction

    function void check_result(logic [31:0] secs, logic bad);
      stamp_t want;
      if (pending_stamps.size() == 0) begin
        $error("result with nothing pending: unix_seconds %0d format_error %0b", secs, bad);
        failures++;
        return;
      end
      want = pending_stamps.pop_front();
      if (secs !== want.secs) begin
        $error("unix_seconds: expected %0d, got %0d", want.secs, secs);
        failures++;
      end
      if (bad !== want.bad) begin
        $error("format_error: expected %0b, got %0b", want.bad, bad);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        final_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] unix_seconds;
  logic        format_error;

  date_scoreboard dates;
  bit             quiet = 1'b0;
  int unsigned    chars_sent = 0;
  int unsigned    cycle_count = 0;
  int unsigned    stall_run = 0;
  int unsigned    stall_pick;

  http_date_to_unix_seconds_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .final_char   (final_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .unix_seconds (unix_seconds),
    .format_error (format_error)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern: free runs, short stalls, a few long ones
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (stall_run == 0) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 50) begin
          out_stall <= 1'b0;
          stall_run = $urandom_range(1, 20);
        end else if (stall_pick < 90) begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(10, 40);
        end
      end
      stall_run--;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) dates.check_result(unix_seconds, format_error);
  end

  // sender gap length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_text(ref byte_q q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void put_num(ref byte_q q, input int unsigned v, input int unsigned digits);
    string t;
    t = $sformatf("%0d", v);
    while (t.len() < digits) t = {"0", t};
    put_text(q, t);
  endfunction

  // random date string, mostly well formed
  function automatic byte_q make_date();
    byte_q       q;
    string       wd [7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
    int unsigned r, m, n;
    // weekday or junk before the comma
    if ($urandom_range(0, 3) != 0) put_text(q, wd[$urandom_range(0, 6)]);
    else repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(65, 122)));
    put_text(q, ",");
    repeat ($urandom_range(0, 2)) put_text(q, " ");
    // day
    r = $urandom_range(0, 19);
    if (r == 1) put_num(q, $urandom_range(100000, 999999), 1);
    else if (r != 0) put_num(q, $urandom_range(0, 31), $urandom_range(1, 2));
    repeat ($urandom_range(0, 2)) put_text(q, " ");
    // month
    if ($urandom_range(0, 9) != 0) begin
      m = $urandom_range(0, 11);
      for (int k = 0; k < 3; k++) q.push_back(hdus_pkg::MONTH_NAMES[287 - m*24 - k*8 -: 8]);
    end else begin
      repeat (3) q.push_back(8'($urandom_range(1, 255)));
    end
    repeat ($urandom_range(0, 2)) put_text(q, " ");
    // year
    r = $urandom_range(0, 19);
    case (r)
      0: ;
      1: put_num(q, $urandom_range(100000, 999999), 1);
      2: put_num(q, $urandom_range(1900, 1969), 1);
      3: put_num(q, $urandom_range(2106, 2300), 1);
      4: begin
        r = $urandom_range(0, 4);
        put_num(q, (r == 0) ? 1970 : (r == 1) ? 2000 : (r == 2) ? 2100 :
                   (r == 3) ? 2104 : 2105, 1);
      end
      default: put_num(q, $urandom_range(1970, 2105), 1);
    endcase
    if ($urandom_range(0, 19) == 0) q.push_back(8'($urandom_range(1, 255)));
    else put_text(q, " ");
    // time of day
    if ($urandom_range(0, 9) == 0) begin
      repeat (8) q.push_back(8'($urandom_range(1, 255)));
    end else begin
      put_num(q, $urandom_range(0, 23), 2);
      put_text(q, ":");
      put_num(q, $urandom_range(0, 59), 2);
      put_text(q, ":");
      put_num(q, $urandom_range(0, 59), 2);
    end
    // trailer
    r = $urandom_range(0, 3);
    if (r == 1 || r == 3) put_text(q, " GMT");
    else if (r == 2) repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(1, 255)));
    // broken strings: cut short, zero byte, or both
    r = $urandom_range(0, 19);
    if (r == 0 || r == 2) begin
      n = $urandom_range(1, q.size());
      while (q.size() > n) void'(q.pop_back());
    end
    if (r == 1 || r == 2) q.insert($urandom_range(0, q.size() - 1), hdus_pkg::CH_NUL);
    return q;
  endfunction

  task automatic send_char(input bit [7:0] c, input bit fin);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    final_char <= fin;
    do @(posedge clk); while (in_stall);
    dates.note_char(c, fin);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input byte_q s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string s);
    byte_q q;
    put_text(q, s);
    send_string(q);
  endtask

  initial begin
    byte_q q;
    dates = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed strings
    send_text("x");                       // no comma at all
    send_text(",1Jan1970 00:00:00");      // epoch, first valid year
    send_text(",0Dec2105 23:59:59 GMT");  // last valid year, day zero, trailer
    send_text(",1Jan1969 00:00:00");      // year below range
    send_text(",1Jan");                   // ends before the year
    send_text(",1Jan1970-");              // no space after the year
    put_text(q, ",1");                    // zero byte in the middle of the string
    q.push_back(hdus_pkg::CH_NUL);
    put_text(q, "Jan");
    send_string(q);

    // random strings
    while (chars_sent < RANDOM_CHARS) begin
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) begin
        q.delete();
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
        send_string(q);
      end else begin
        send_string(make_date());
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // drain
    while (dates.pending_stamps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (dates.failures == 0 && dates.pending_stamps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
